// ===== sv/qkn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkn_pkg
// Shared widths, codes and constants of the quadrature knob decoder.
// ----------------------------------------------------------------------------
package qkn_pkg;

  localparam int NumEnc = 16;
  localparam int EncW   = 4;

  // Register indexes of the configuration port
  localparam logic [2:0] CfgLeftSeq  = 3'd0;
  localparam logic [2:0] CfgRightSeq = 3'd1;
  localparam logic [2:0] CfgRevMask  = 3'd2;
  localparam logic [2:0] CfgMinVal   = 3'd3;
  localparam logic [2:0] CfgMaxVal   = 3'd4;
  localparam logic [2:0] CfgPeriod   = 3'd5;

  // Direction codes of a result beat
  localparam logic [1:0] DirNone = 2'd0;
  localparam logic [1:0] DirUp   = 2'd1;
  localparam logic [1:0] DirDown = 2'd2;

  localparam int SeqLen     = 4;
  localparam int FastGapMs  = 250;
  localparam int AccelNum   = 250000;
  localparam int AccelDen   = 1000;
  // (n / g) / d == n / (g * d), so the fast step is AccelQuot / g
  localparam int AccelQuot  = AccelNum / AccelDen;
  localparam int SpeedScale = 1000;

  // Shared divider: 10-bit dividend, 10-bit divisor
  localparam int DivW = 10;

  localparam logic [15:0] KnobReset = 16'd63;

  // Progress of one direction against its four-code sequence
  function automatic logic [2:0] seq_advance(input logic [7:0] seq,
                                             input logic [2:0] pos,
                                             input logic [1:0] code);
    logic [1:0] want;
    want = seq[{pos[1:0], 1'b0} +: 2];
    return (want == code) ? (pos + 3'd1) : 3'd0;
  endfunction

endpackage

// ===== sv/quadrature_knob_with_acceleration.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_with_acceleration
// Multi-encoder quadrature decoder with detent matching, acceleration,
// clamped knob values and a per-encoder speed meter.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (tdata, low bit first)
//  --------  ---------  ---------------------------------------------------
//  s_axis    in         encoder[3:0] phase_a[4] phase_b[5] time_ms[37:6]
//  m_axis    out        knob_value[15:0] stepped[16] direction[18:17]
//                       step_size[26:19] speed[42:27]
//  cfg       in         cfg_index_i (register 0..5), cfg_data_i (16 bits)
//
//  One beat at a time. A beat is taken in idle and evaluated the next cycle;
//  a detent then passes through the divider, multiply and window states if
//  the speed window closes, the divider again if the gap is short, and the
//  step and clamp states, before the done state loads the result beat into
//  the output register. The shared 10-step restoring divider runs once for
//  1000/period and once for 250/gap. Reset (async, active low) loads all
//  per-encoder state, configuration, sequencer and output valid, not beat data.
//  A stalled output holds the finished beat; the next input beat is accepted
//  meanwhile, and its result waits in the done state until the register frees.
// ----------------------------------------------------------------------------
module quadrature_knob_with_acceleration
  import qkn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input sample
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // encoder, phase_a, phase_b, time_ms
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // knob_value, stepped, direction,
                                      // step_size, speed
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_DIVP  = 4'd2;  // 1000 / period
  localparam logic [3:0] S_MUL   = 4'd3;  // count * quotient
  localparam logic [3:0] S_WIN   = 4'd4;  // saturate, store speed
  localparam logic [3:0] S_DIVG  = 4'd5;  // 250 / gap
  localparam logic [3:0] S_STEP  = 4'd6;  // knob +/- step
  localparam logic [3:0] S_CLAMP = 4'd7;  // clamp, store knob
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [DivW-1:0] DivLast = DivW'(DivW - 1);

  // Configuration registers
  logic [7:0]        left_seq_q, right_seq_q;
  logic [NumEnc-1:0] rev_mask_q;
  logic [15:0]       min_val_q, max_val_q;
  logic [9:0]        period_q;

  // Per-encoder state
  logic [1:0]  last_code_q  [NumEnc];
  logic [2:0]  lprog_q      [NumEnc];
  logic [2:0]  rprog_q      [NumEnc];
  logic [15:0] knob_q       [NumEnc];
  logic [15:0] dcount_q     [NumEnc];
  logic [15:0] speed_q      [NumEnc];
  logic [31:0] wstart_q     [NumEnc];
  logic [31:0] last_det_q   [NumEnc];

  logic [3:0]  state_q, state_d;

  // Latched sample
  logic [EncW-1:0] enc_q;
  logic [1:0]      code_q;
  logic [31:0]     time_q;

  // Working registers of one beat
  logic        taken_q, fast_q;
  logic [1:0]  dir_q;
  logic [7:0]  g_q, stp_q;
  logic [15:0] cnt_inc_q;
  logic [25:0] prod_q;
  logic signed [17:0] sum_q;

  // Shared divider
  logic [DivW-1:0] rem_q, quo_q, den_q;
  logic [DivW-1:0] div_cnt_q;
  logic [DivW:0]   trial;
  logic            trial_ge;
  logic            div_done;

  // Output register
  logic        m_valid_q;
  logic [47:0] m_data_q;

  // Evaluation logic
  logic [1:0]  cur_code;
  logic        changed;
  logic [2:0]  lp_n, rp_n;
  logic        l4, r4, taken_n, cw_n, up_n;
  logic [31:0] gap, elapsed;
  logic        fast_n, win_n;
  logic [7:0]  g_n;
  logic [9:0]  per_eff;
  logic [15:0] cnt_cur, cnt_inc_n;
  logic [15:0] speed_sat;
  logic [7:0]  stp_sel;
  logic signed [17:0] max_ext, min_ext, k_hi, k_lo;
  logic        out_free;

  assign cur_code  = code_q;
  assign changed   = cur_code != last_code_q[enc_q];
  assign lp_n      = seq_advance(left_seq_q,  lprog_q[enc_q], cur_code);
  assign rp_n      = seq_advance(right_seq_q, rprog_q[enc_q], cur_code);
  assign l4        = lp_n == 3'(SeqLen);
  assign r4        = rp_n == 3'(SeqLen);
  // both directions completing at once cancel each other
  assign taken_n   = changed & (l4 ^ r4);
  assign cw_n      = r4 & ~l4;
  assign up_n      = cw_n ^ rev_mask_q[enc_q];

  assign gap       = time_q - last_det_q[enc_q];
  assign fast_n    = gap < 32'(FastGapMs);
  assign g_n       = (gap == 32'd0) ? 8'd1 : gap[7:0];
  assign per_eff   = (period_q == 10'd0) ? 10'd1 : period_q;
  assign elapsed   = time_q - wstart_q[enc_q];
  assign win_n     = elapsed >= {22'd0, per_eff};
  assign cnt_cur   = dcount_q[enc_q];
  assign cnt_inc_n = (cnt_cur == 16'hFFFF) ? cnt_cur : cnt_cur + 16'd1;

  assign speed_sat = (|prod_q[25:16]) ? 16'hFFFF : prod_q[15:0];
  assign stp_sel   = fast_q ? quo_q[7:0] : 8'd1;

  assign max_ext   = $signed({2'b00, max_val_q});
  assign min_ext   = $signed({2'b00, min_val_q});
  assign k_hi      = (sum_q > max_ext) ? max_ext : sum_q;
  assign k_lo      = (k_hi < min_ext) ? min_ext : k_hi;

  // One restoring step per cycle, quotient bits shift in from the bottom
  assign trial     = {rem_q, quo_q[DivW-1]};
  assign trial_ge  = trial >= {1'b0, den_q};
  assign div_done  = div_cnt_q == DivLast;

  assign out_free  = ~m_valid_q | m_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_EVAL;
      S_EVAL: begin
        if (!taken_n)     state_d = S_DONE;
        else if (win_n)   state_d = S_DIVP;
        else if (fast_n)  state_d = S_DIVG;
        else              state_d = S_STEP;
      end
      S_DIVP:  if (div_done) state_d = S_MUL;
      S_MUL:   state_d = S_WIN;
      S_WIN:   state_d = fast_q ? S_DIVG : S_STEP;
      S_DIVG:  if (div_done) state_d = S_STEP;
      S_STEP:  state_d = S_CLAMP;
      S_CLAMP: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_seq_q  <= 8'd225;
      right_seq_q <= 8'd210;
      rev_mask_q  <= '0;
      min_val_q   <= 16'd0;
      max_val_q   <= 16'd127;
      period_q    <= 10'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLeftSeq:  left_seq_q  <= cfg_data_i[7:0];
        CfgRightSeq: right_seq_q <= cfg_data_i[7:0];
        CfgRevMask:  rev_mask_q  <= cfg_data_i[NumEnc-1:0];
        CfgMinVal:   min_val_q   <= cfg_data_i;
        CfgMaxVal:   max_val_q   <= cfg_data_i;
        CfgPeriod:   period_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Beat datapath (no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q) inside
      S_IDLE: begin
        enc_q  <= s_axis_tdata[3:0];
        code_q <= {s_axis_tdata[5], s_axis_tdata[4]};
        time_q <= s_axis_tdata[37:6];
      end
      S_EVAL: begin
        taken_q   <= taken_n;
        fast_q    <= fast_n;
        g_q       <= g_n;
        cnt_inc_q <= cnt_inc_n;
        stp_q     <= 8'd1;
        dir_q     <= !taken_n ? DirNone : (up_n ? DirUp : DirDown);
        div_cnt_q <= '0;
        rem_q     <= '0;
        if (win_n) begin
          quo_q <= DivW'(SpeedScale);
          den_q <= per_eff;
        end else begin
          quo_q <= DivW'(AccelQuot);
          den_q <= {2'b00, g_n};
        end
      end
      S_DIVP, S_DIVG: begin
        rem_q     <= trial_ge ? trial[DivW-1:0] - den_q : trial[DivW-1:0];
        quo_q     <= {quo_q[DivW-2:0], trial_ge};
        div_cnt_q <= div_cnt_q + DivW'(1);
      end
      S_MUL: prod_q <= 26'(cnt_inc_q) * 26'(quo_q);
      S_WIN: begin
        div_cnt_q <= '0;
        rem_q     <= '0;
        quo_q     <= DivW'(AccelQuot);
        den_q     <= {2'b00, g_q};
      end
      S_STEP: begin
        stp_q <= stp_sel;
        if (dir_q == DirUp) begin
          sum_q <= $signed({2'b00, knob_q[enc_q]}) + $signed({10'd0, stp_sel});
        end else begin
          sum_q <= $signed({2'b00, knob_q[enc_q]}) - $signed({10'd0, stp_sel});
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-encoder state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NumEnc; e++) begin
        last_code_q[e] <= '0;
        lprog_q[e]     <= '0;
        rprog_q[e]     <= '0;
        knob_q[e]      <= KnobReset;
        dcount_q[e]    <= '0;
        speed_q[e]     <= '0;
        wstart_q[e]    <= '0;
        last_det_q[e]  <= '0;
      end
    end else begin
      case (state_q)
        S_EVAL: begin
          if (changed) begin
            last_code_q[enc_q] <= cur_code;
            lprog_q[enc_q]     <= (l4 | r4) ? 3'd0 : lp_n;
            rprog_q[enc_q]     <= (l4 | r4) ? 3'd0 : rp_n;
          end
          if (taken_n) begin
            last_det_q[enc_q] <= time_q;
            dcount_q[enc_q]   <= win_n ? 16'd0 : cnt_inc_n;
            if (win_n) wstart_q[enc_q] <= time_q;
          end
        end
        S_WIN:   speed_q[enc_q] <= speed_sat;
        S_CLAMP: knob_q[enc_q]  <= k_lo[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {5'd0, speed_q[enc_q], (taken_q ? stp_q : 8'd0), dir_q,
                   taken_q, knob_q[enc_q]};
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_EVAL)
    else $error("accepted beat not evaluated next cycle");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVP || state_q == S_DIVG) |-> rem_q < den_q)
    else $error("divider remainder out of range");

  a_step_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |->
      m_axis_tdata[18:17] != DirNone && m_axis_tdata[26:19] != 8'd0)
    else $error("detent beat without direction or step");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[16] |->
      m_axis_tdata[18:17] == DirNone && m_axis_tdata[26:19] == 8'd0)
    else $error("non-detent beat carries a step");

endmodule

// ===== verif/tb_quadrature_knob_with_acceleration.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_knob_with_acceleration
// Self-checking bench for the multi-encoder knob decoder. A short stimulus table
// walks detents in both directions, time wrap and a broken run; a run of detents
// inside one window on one encoder drives the speed into saturation; random
// phases then drive mostly well-formed detent runs under several register
// settings. Every beat is checked field by field against a typed row's expected
// beat or an in-bench model of the knob, progress, acceleration and speed logic.
// ----------------------------------------------------------------------------
module tb_quadrature_knob_with_acceleration;
  import qkn_pkg::*;

  // Timing limits, in clock cycles
  localparam int WatchdogLimit     = 2000;  // cycles with no beat on any channel
  localparam int HoldCycles        = 400;   // one long receiver hold-off
  localparam int SettleCycles      = 32;    // above the worst-case item latency
  localparam int DetentsToSatSpeed = 66;    // 66 * 1000 is past the 16-bit speed limit

  // Result beat, knob_value in the low bits as on m_axis_tdata
  typedef struct packed {
    logic [15:0] speed;
    logic [7:0]  step_size;
    logic [1:0]  direction;
    logic        stepped;
    logic [15:0] knob_value;
  } knob_beat_t;

  localparam knob_beat_t NoBeat = '0;

  // One row of the directed stimulus; the expectation is used when typed is set
  typedef struct packed {
    logic [3:0]  encoder;
    logic        phase_a;
    logic        phase_b;
    logic [31:0] time_ms;
    logic        typed;
    knob_beat_t  want;
  } sample_row_t;

  // Register settings and stimulus shape of one random phase
  typedef struct packed {
    logic [7:0]  left_seq;
    logic [7:0]  right_seq;
    logic [15:0] rev_mask;
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [9:0]  period_ms;
    int          n_items;
    int          enc_hi;     // encoders drawn from 0..enc_hi
    int          still_pct;  // chance that time stands still between samples
    logic        steady;     // no idling on either side
    logic        rand_regs;  // draw sequences and reverse mask at random
  } phase_t;

  // Reset config: left codes 1,0,2,3 and right codes 2,0,1,3
  localparam int NumRows = 24;
  localparam sample_row_t DirectedRows [NumRows] = '{
    // same code as after reset: ignored
    '{4'd0, 1'b0, 1'b0, 32'd0, 1'b1,
      '{knob_value:16'd63, stepped:1'b0, direction:DirNone, step_size:8'd0, speed:16'd0}},
    '{4'd0, 1'b1, 1'b0, 32'd10, 1'b0, NoBeat},
    '{4'd0, 1'b0, 1'b0, 32'd20, 1'b0, NoBeat},
    '{4'd0, 1'b0, 1'b1, 32'd30, 1'b0, NoBeat},
    // slow counterclockwise detent, speed window closes
    '{4'd0, 1'b1, 1'b1, 32'd1000, 1'b1,
      '{knob_value:16'd62, stepped:1'b1, direction:DirDown, step_size:8'd1, speed:16'd10}},
    '{4'd0, 1'b0, 1'b1, 32'd1001, 1'b0, NoBeat},
    '{4'd0, 1'b0, 1'b0, 32'd1001, 1'b0, NoBeat},
    '{4'd0, 1'b1, 1'b0, 32'd1001, 1'b0, NoBeat},
    // 1 ms gap: largest step, clamped at max
    '{4'd0, 1'b1, 1'b1, 32'd1001, 1'b1,
      '{knob_value:16'd127, stepped:1'b1, direction:DirUp, step_size:8'd250, speed:16'd10}},
    // repeat of the last code
    '{4'd0, 1'b1, 1'b1, 32'd5000, 1'b1,
      '{knob_value:16'd127, stepped:1'b0, direction:DirNone, step_size:8'd0, speed:16'd10}},
    // detents on both sides of the timestamp wrap
    '{4'd1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, NoBeat},
    '{4'd1, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, NoBeat},
    '{4'd1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, NoBeat},
    '{4'd1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{knob_value:16'd62, stepped:1'b1, direction:DirDown, step_size:8'd1, speed:16'd10}},
    '{4'd1, 1'b0, 1'b1, 32'd99, 1'b0, NoBeat},
    '{4'd1, 1'b0, 1'b0, 32'd99, 1'b0, NoBeat},
    '{4'd1, 1'b1, 1'b0, 32'd99, 1'b0, NoBeat},
    '{4'd1, 1'b1, 1'b1, 32'd99, 1'b0, NoBeat},
    // broken run: a wrong code clears progress
    '{4'd2, 1'b1, 1'b0, 32'd5, 1'b0, NoBeat},
    '{4'd2, 1'b0, 1'b0, 32'd5, 1'b0, NoBeat},
    '{4'd2, 1'b1, 1'b1, 32'd5, 1'b0, NoBeat},
    '{4'd2, 1'b0, 1'b1, 32'd6, 1'b0, NoBeat},
    '{4'd2, 1'b1, 1'b1, 32'd7, 1'b0, NoBeat},
    '{4'd14, 1'b1, 1'b1, 32'h8000_0000, 1'b0, NoBeat}
  };

  localparam int NumPhases = 8;
  localparam phase_t Phases [NumPhases] = '{
    // reset values written back
    '{8'hE1, 8'hD2, 16'h0000, 16'd0, 16'd127, 10'd100, 100, 15, 30, 1'b0, 1'b0},
    // 1 ms window, one encoder, time mostly frozen: high speeds
    '{8'hE1, 8'hD2, 16'hFFFF, 16'd0, 16'hFFFF, 10'd1, 200, 0, 97, 1'b0, 1'b0},
    // equal sequences: both directions complete together; zero period
    '{8'hE1, 8'hE1, 16'h5A5A, 16'd10, 16'd500, 10'd0, 100, 7, 30, 1'b0, 1'b0},
    // min above max
    '{8'h00, 8'h00, 16'h0000, 16'd200, 16'd100, 10'd1023, 100, 15, 30, 1'b0, 1'b1},
    '{8'h4B, 8'h1E, 16'hA5A5, 16'd0, 16'hFFFF, 10'd1000, 150, 3, 30, 1'b1, 1'b0},
    '{8'hFF, 8'h00, 16'h0F0F, 16'hFFFF, 16'hFFFF, 10'd7, 75, 15, 30, 1'b0, 1'b0},
    '{8'h00, 8'h00, 16'h0000, 16'd1000, 16'd1200, 10'd250, 100, 15, 30, 1'b0, 1'b1},
    '{8'hE1, 8'hD2, 16'h00FF, 16'd0, 16'd0, 10'd3, 75, 15, 50, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // encoder, phase_a, phase_b, time_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // knob_value, stepped, direction, step_size, speed
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  quadrature_knob_with_acceleration u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Bench-side copy of the registers
  logic [7:0]  left_seq_r;
  logic [7:0]  right_seq_r;
  logic [15:0] rev_mask_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [9:0]  period_r;

  // Bench-side copy of the per-encoder state
  logic [1:0]  prev_code   [NumEnc];
  logic [2:0]  left_prog   [NumEnc];
  logic [2:0]  right_prog  [NumEnc];
  logic [15:0] knob_pos    [NumEnc];
  logic [15:0] detent_cnt  [NumEnc];
  logic [15:0] speed_meas  [NumEnc];
  logic [31:0] win_start   [NumEnc];
  logic [31:0] last_detent [NumEnc];

  knob_beat_t pending_knob_beats [$];
  int         mismatch_count;
  int         quiet_cycles;
  logic       steady;     // both sides stop idling
  logic       hold_req;   // asks the receiver for its long hold-off
  logic       hold_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Knob model
  // --------------------------------------------------------------------------
  function automatic logic [2:0] match_code(input logic [7:0] codes, input logic [2:0] pos,
                                            input logic [1:0] code);
    return (codes[2 * pos[1:0] +: 2] == code) ? pos + 3'd1 : 3'd0;
  endfunction

  function automatic void clear_knob_state();
    left_seq_r  = 8'd225;
    right_seq_r = 8'd210;
    rev_mask_r  = 16'd0;
    min_r       = 16'd0;
    max_r       = 16'd127;
    period_r    = 10'd100;
    for (int e = 0; e < NumEnc; e++) begin
      prev_code[e]   = 2'd0;
      left_prog[e]   = 3'd0;
      right_prog[e]  = 3'd0;
      knob_pos[e]    = KnobReset;
      detent_cnt[e]  = 16'd0;
      speed_meas[e]  = 16'd0;
      win_start[e]   = 32'd0;
      last_detent[e] = 32'd0;
    end
  endfunction

  // Applies one sample to the model state and returns its result beat
  function automatic knob_beat_t predict_knob(input logic [3:0] enc, input logic pa,
                                              input logic pb, input logic [31:0] now);
    logic [1:0]  code;
    logic [2:0]  lp, rp;
    logic        taken, cw;
    logic [31:0] gap, per, spd, amt;
    int          k;
    knob_beat_t  r;
    r    = NoBeat;
    code = {pb, pa};
    if (code != prev_code[enc]) begin
      lp    = match_code(left_seq_r, left_prog[enc], code);
      rp    = match_code(right_seq_r, right_prog[enc], code);
      taken = (lp == SeqLen);
      cw    = 1'b0;
      if (rp == SeqLen) begin
        // both directions done at once cancel out
        cw    = !taken;
        taken = !taken;
        lp    = 3'd0;
        rp    = 3'd0;
      end
      if (taken) begin
        lp  = 3'd0;
        rp  = 3'd0;
        gap = now - last_detent[enc];
        per = (period_r == 10'd0) ? 32'd1 : 32'(period_r);
        if (detent_cnt[enc] != 16'hFFFF) detent_cnt[enc]++;
        if (now - win_start[enc] >= per) begin
          spd = 32'(detent_cnt[enc]) * (32'(SpeedScale) / per);
          speed_meas[enc] = (spd > 32'hFFFF) ? 16'hFFFF : spd[15:0];
          win_start[enc]  = now;
          detent_cnt[enc] = 16'd0;
        end
        amt = 32'd1;
        last_detent[enc] = now;
        if (gap < 32'(FastGapMs)) begin
          amt = (32'(AccelNum) / ((gap == 0) ? 32'd1 : gap)) / 32'(AccelDen);
        end
        k = int'(knob_pos[enc]);
        if (cw ^ rev_mask_r[enc]) begin
          k = k + int'(amt);
          r.direction = DirUp;
        end else begin
          k = k - int'(amt);
          r.direction = DirDown;
        end
        if (k > int'(max_r)) k = int'(max_r);
        if (k < int'(min_r)) k = int'(min_r);
        knob_pos[enc] = k[15:0];
        r.stepped     = 1'b1;
        r.step_size   = amt[7:0];
      end
      left_prog[enc]  = lp;
      right_prog[enc] = rp;
      prev_code[enc]  = code;
    end
    r.knob_value = knob_pos[enc];
    r.speed      = speed_meas[enc];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left at a rising edge
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [3:0] enc, input logic pa, input logic pb,
                             input logic [31:0] t, input logic typed,
                             input knob_beat_t want);
    int         gap;
    knob_beat_t beat;
    gap = 0;
    if (!steady) begin
      while (gap < 20 && $urandom_range(99) < 25) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t, pb, pa, enc};
    do @(negedge clk_i); while (!s_axis_tready);
    // beat goes in at the coming edge
    beat = predict_knob(enc, pa, pb, t);
    if (typed) beat = want;
    pending_knob_beats.push_back(beat);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgLeftSeq:  left_seq_r  = val[7:0];
      CfgRightSeq: right_seq_r = val[7:0];
      CfgRevMask:  rev_mask_r  = val;
      CfgMinVal:   min_r       = val;
      CfgMaxVal:   max_r       = val;
      CfgPeriod:   period_r    = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_settings(input phase_t p);
    write_reg(CfgLeftSeq, {8'd0, p.left_seq});
    write_reg(CfgRightSeq, {8'd0, p.right_seq});
    write_reg(CfgRevMask, p.rev_mask);
    write_reg(CfgMinVal, p.min_value);
    write_reg(CfgMaxVal, p.max_value);
    write_reg(CfgPeriod, {6'd0, p.period_ms});
    cfg_valid_i <= 1'b0;
  endtask

  // Sender stops and waits for every outstanding result, then for the pipe to settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_knob_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] time_step(input int still_pct);
    if ($urandom_range(99) < still_pct) return 32'd0;
    case ($urandom_range(2))
      0:       return 32'($urandom_range(9, 1));
      1:       return 32'($urandom_range(300, 10));
      default: return 32'($urandom_range(3000, 200));
    endcase
  endfunction

  // Mostly whole detent runs from the current sequences, some broken, rest noise
  task automatic run_phase(input phase_t p);
    logic [31:0] now;
    logic [7:0]  codes;
    logic [3:0]  enc;
    logic [1:0]  code;
    int          issued, i, cut;
    now    = $urandom();
    issued = 0;
    while (issued < p.n_items) begin
      enc = 4'($urandom_range(p.enc_hi, 0));
      if ($urandom_range(99) < 75) begin
        codes = $urandom_range(1) ? left_seq_r : right_seq_r;
        cut   = ($urandom_range(9) == 0) ? int'($urandom_range(SeqLen - 1)) : SeqLen;
        for (i = 0; i < SeqLen; i++) begin
          code = (i == cut) ? 2'($urandom_range(3)) : codes[2 * i +: 2];
          now  = now + time_step(p.still_pct);
          send_sample(enc, code[0], code[1], now, 1'b0, NoBeat);
        end
        issued = issued + SeqLen;
      end else begin
        code = 2'($urandom_range(3));
        if ($urandom_range(3) == 0) begin
          send_sample(enc, code[0], code[1], $urandom(), 1'b0, NoBeat);
        end else begin
          now = now + time_step(p.still_pct);
          send_sample(enc, code[0], code[1], now, 1'b0, NoBeat);
        end
        issued++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, one long hold-off, none while steady
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 25);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker and watchdog. Sampled mid-cycle: a handshake seen here completes
  // at the next rising edge, since nothing changes in between.
  // --------------------------------------------------------------------------
  initial begin
    knob_beat_t want, got;
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni) begin
        if (m_axis_tvalid && m_axis_tready) begin
          got = knob_beat_t'(m_axis_tdata[42:0]);
          if (pending_knob_beats.size() == 0) begin
            $error("result beat with no sample outstanding: %h", m_axis_tdata);
            mismatch_count++;
          end else begin
            want = pending_knob_beats.pop_front();
            if (got.knob_value !== want.knob_value) begin
              $error("knob_value: expected %0d, got %0d", want.knob_value, got.knob_value);
              mismatch_count++;
            end
            if (got.stepped !== want.stepped) begin
              $error("stepped: expected %0d, got %0d", want.stepped, got.stepped);
              mismatch_count++;
            end
            if (got.direction !== want.direction) begin
              $error("direction: expected %0d, got %0d", want.direction, got.direction);
              mismatch_count++;
            end
            if (got.step_size !== want.step_size) begin
              $error("step_size: expected %0d, got %0d", want.step_size, got.step_size);
              mismatch_count++;
            end
            if (got.speed !== want.speed) begin
              $error("speed: expected %0d, got %0d", want.speed, got.speed);
              mismatch_count++;
            end
          end
        end
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (cfg_valid_i && cfg_ready_o)) begin
          quiet_cycles = 0;
        end else begin
          quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int         r, j, i;
    phase_t     p;
    logic [1:0] code;
    mismatch_count = 0;
    steady         = 1'b0;
    hold_req       = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgLeftSeq;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    clear_knob_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under reset register values
    for (r = 0; r < NumRows; r++) begin
      send_sample(DirectedRows[r].encoder, DirectedRows[r].phase_a, DirectedRows[r].phase_b,
                  DirectedRows[r].time_ms, DirectedRows[r].typed, DirectedRows[r].want);
    end
    drain_results();

    // Speed saturation on encoder 15 (untouched so far). Times alternate
    // between 300 and 0 so the 1000 ms window never closes while every gap is slow.
    steady = 1'b1;
    p = Phases[0];
    p.max_value = 16'hFFFF;
    p.period_ms = 10'd1000;
    load_settings(p);
    for (j = 0; j < DetentsToSatSpeed; j++) begin
      for (i = 0; i < SeqLen; i++) begin
        code = left_seq_r[2 * i +: 2];
        send_sample(4'd15, code[0], code[1], j[0] ? 32'd0 : 32'd300, 1'b0, NoBeat);
      end
    end
    drain_results();
    // 1 ms window now closes on the next detent: 67 * 1000 saturates
    p.period_ms = 10'd1;
    load_settings(p);
    for (i = 0; i < SeqLen; i++) begin
      code = left_seq_r[2 * i +: 2];
      send_sample(4'd15, code[0], code[1], 32'd2000, (i == SeqLen - 1),
                  '{knob_value:16'd0, stepped:1'b1, direction:DirDown,
                    step_size:8'd1, speed:16'hFFFF});
    end
    drain_results();
    steady = 1'b0;

    // Random phases, register writes only between them with the block drained
    for (r = 0; r < NumPhases; r++) begin
      p = Phases[r];
      if (p.rand_regs) begin
        p.left_seq  = 8'($urandom());
        p.right_seq = 8'($urandom());
        p.rev_mask  = 16'($urandom());
      end
      load_settings(p);
      steady   = p.steady;
      hold_req = (r == 0);
      run_phase(p);
      drain_results();
      steady = 1'b0;
    end

    if (mismatch_count == 0 && pending_knob_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
